// ===== rtl/sdre_pkg.sv =====
// Shared types and codes for the square draw raster engine.
`default_nettype none

package sdre_pkg;

  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_DRAW = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STYLE_NONE0   = 2'd0,
    STYLE_OUTLINE = 2'd1,
    STYLE_FILLED  = 2'd2,
    STYLE_NONE3   = 2'd3
  } style_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_t;

  localparam int CW          = 9;    // coordinate / size width
  localparam int FIELD_W     = 8;    // width of an input coordinate or colour
  localparam int SIZE_RESET  = 256;

endpackage : sdre_pkg

`default_nettype wire

// ===== rtl/square_draw_raster_engine.sv =====
// Top level of the square draw raster engine: sequencer, rectangle walker, frame buffer.
`default_nettype none
//
// Grayscale frame buffer that executes one command per input request.
//  in_*   : command request. in_tuser = cmd (0 fill, 1 draw square, 2 read, 3 nop).
//  out_*  : one result per request: out_tdata = pixel value (zero unless a read),
//           out_tuser = status (1: square out of bounds or read outside image).
//  cfg_*  : write of image_size (side of the active image), always ready.
//           Write it only while the engine is idle.
// Flow: a request is taken in IDLE and decoded in CHECK, then walked (WALK),
//  read (READ) or skipped, and DONE loads the result register once the output
//  register is free. The walker writes one pixel per cycle through the single
//  frame buffer write port; fill writes size*size pixels, a filled square
//  (2r+1)^2, an outline 2*(2r+1) + 2*(2r-1) (one pixel for r = 0). Skipped
//  squares and nop go from CHECK straight to DONE. in_tready is high only while idle.
// Reset clears the sequencer and the result valid; image_size returns to 256.
//  The frame buffer is not cleared; pixels read before they are written are
//  undefined.
// If the receiver stalls, the finished result waits in the output register;
//  the engine still takes and works the next request and holds its result
//  until the output register frees up.

module square_draw_raster_engine #(
  parameter int MAX_SIZE   = 256,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cfg_data: image_size[8:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  // in_tdata: center_col[7:0], center_row[15:8], radius[23:16], colour[31:24],
  //           style[33:32], zero[39:34]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  wire logic [1:0]  in_tuser,
  // out_tdata: pixel_value[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  // out_tuser: status[0]
  output logic [0:0]       out_tuser
);
  import sdre_pkg::*;

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------- configuration ----------------
  logic [CW-1:0] image_size_r;
  logic [CW-1:0] size_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= CW'(SIZE_RESET);
    end else if (cfg_valid) begin
      image_size_r <= cfg_data;
    end
  end

  // active size: zero acts as one, clamp to the buffer side
  always_comb begin
    if (image_size_r == '0) begin
      size_w = CW'(1);
    end else if (32'(image_size_r) > MAX_SIZE) begin
      size_w = CW'(MAX_SIZE);
    end else begin
      size_w = image_size_r;
    end
  end

  // ---------------- registers ----------------
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  style_t              style_r, style_nxt;
  logic [FIELD_W-1:0]  col_r, col_nxt;
  logic [FIELD_W-1:0]  row_r, row_nxt;
  logic [FIELD_W-1:0]  rad_r, rad_nxt;
  logic [FIELD_W-1:0]  colour_r, colour_nxt;
  logic [CW-1:0]       r_r, r_nxt, c_r, c_nxt;
  logic [CW-1:0]       r0_r, r0_nxt, r1_r, r1_nxt;
  logic [CW-1:0]       c0_r, c0_nxt, c1_r, c1_nxt;
  logic [AW-1:0]       base_r, base_nxt;
  logic                outline_r, outline_nxt;
  logic                status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_data_r, out_data_nxt;
  logic                out_stat_r, out_stat_nxt;

  // ---------------- frame buffer ----------------
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_q;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;

  assign waddr = base_r + AW'(c_r);
  assign raddr = AW'(32'(row_r) * MAX_SIZE + 32'(col_r));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= PIXEL_BITS'(colour_r);
    end
    rd_q <= mem[raddr];
  end

  // ---------------- decode helpers ----------------
  logic [CW-1:0] row_w, col_w, rad_w;
  logic          draw_oob, read_oob;
  logic          row_end, last_row, on_edge_row;
  logic          out_free;

  assign row_w = CW'(row_r);
  assign col_w = CW'(col_r);
  assign rad_w = CW'(rad_r);

  assign draw_oob = (row_w < rad_w) || (col_w < rad_w) ||
                    (row_w + rad_w >= size_w) || (col_w + rad_w >= size_w);
  assign read_oob = (row_w >= size_w) || (col_w >= size_w);

  assign row_end     = (c_r == c1_r);
  assign last_row    = (r_r == r1_r);
  assign on_edge_row = (r_r == r0_r) || (r_r == r1_r);
  assign out_free    = !out_valid_r || out_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        case (cmd_r)
          CMD_FILL: state_nxt = ST_WALK;
          CMD_DRAW: begin
            if (!draw_oob && (style_r == STYLE_OUTLINE || style_r == STYLE_FILLED)) begin
              state_nxt = ST_WALK;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          CMD_READ: state_nxt = read_oob ? ST_DONE : ST_READ;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_WALK: begin
        if (row_end && last_row) state_nxt = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    cmd_nxt       = cmd_r;
    style_nxt     = style_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rad_nxt       = rad_r;
    colour_nxt    = colour_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    base_nxt      = base_r;
    outline_nxt   = outline_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    we            = 1'b0;
    in_tready     = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        cmd_nxt    = cmd_t'(in_tuser);
        col_nxt    = in_tdata[7:0];
        row_nxt    = in_tdata[15:8];
        rad_nxt    = in_tdata[23:16];
        colour_nxt = in_tdata[31:24];
        style_nxt  = style_t'(in_tdata[33:32]);
        status_nxt = 1'b0;
      end
      ST_CHECK: begin
        if (cmd_r == CMD_FILL) begin
          r0_nxt      = '0;
          c0_nxt      = '0;
          r1_nxt      = size_w - CW'(1);
          c1_nxt      = size_w - CW'(1);
          r_nxt       = '0;
          c_nxt       = '0;
          base_nxt    = '0;
          outline_nxt = 1'b0;
        end else begin
          r0_nxt      = row_w - rad_w;
          r1_nxt      = row_w + rad_w;
          c0_nxt      = col_w - rad_w;
          c1_nxt      = col_w + rad_w;
          r_nxt       = row_w - rad_w;
          c_nxt       = col_w - rad_w;
          base_nxt    = AW'(32'(row_w - rad_w) * MAX_SIZE);
          outline_nxt = (style_r == STYLE_OUTLINE);
        end
        if ((cmd_r == CMD_DRAW && draw_oob) || (cmd_r == CMD_READ && read_oob)) begin
          status_nxt = 1'b1;
        end
      end
      ST_WALK: begin
        we = 1'b1;
        if (row_end) begin
          r_nxt    = r_r + CW'(1);
          c_nxt    = c0_r;
          base_nxt = base_r + AW'(MAX_SIZE);
        end else if (outline_r && !on_edge_row) begin
          // interior row of an outline: jump to the right edge
          c_nxt = c1_r;
        end else begin
          c_nxt = c_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = status_r;
          out_data_nxt  = (cmd_r == CMD_READ && !status_r) ? 8'(rd_q) : 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    style_r    <= style_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    rad_r      <= rad_nxt;
    colour_r   <= colour_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    base_r     <= base_nxt;
    outline_r  <= outline_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_stat_r;

endmodule : square_draw_raster_engine

`default_nettype wire

// ===== tb/square_draw_raster_engine_tb.sv =====
// Self-checking testbench for the square draw raster engine: directed table, then random phases.
`timescale 1ns / 1ps

module square_draw_raster_engine_tb;
  import sdre_pkg::*;

  localparam int SIDE_MAX = 256;
  localparam int HOLD_OFF_CYCLES = 400;

  // Expected result of one request, in port order: pixel in tdata, status in tuser.
  typedef struct packed {
    logic [7:0] pixel;
    logic       status;
  } raster_result_t;

  // One row of the directed table: either a size write or a command request.
  typedef struct packed {
    bit         is_cfg;
    logic [8:0] size;
    cmd_t       cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] rad;
    logic [7:0] colour;
    style_t     style;
    bit         typed;
    logic [7:0] exp_pixel;
    logic       exp_status;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;

  // Predictor state: pixel store indexed row * SIDE_MAX + col, and the size register.
  logic [7:0]     frame_model [0:SIDE_MAX*SIDE_MAX-1];
  logic [8:0]     img_size_model;
  raster_result_t pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int err_count;

  square_draw_raster_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #(50_000_000);
    $display("[square_draw_raster_engine] ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // Size 0 acts as 1, anything past the buffer side acts as the full side.
  function automatic int active_side(input logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  task automatic paint_box(input int r0, input int r1, input int c0, input int c1,
                           input logic [7:0] v);
    for (int rr = r0; rr <= r1; rr++)
      for (int cc = c0; cc <= c1; cc++)
        frame_model[rr*SIDE_MAX + cc] = v;
  endtask

  // Applies one command to the predictor state and returns its result.
  task automatic raster_apply(input cmd_t op, input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] rad, input logic [7:0] colour,
                              input style_t sty, output raster_result_t res);
    int side, c, r, k;
    side = active_side(img_size_model);
    c = col;
    r = row;
    k = rad;
    res = '0;
    case (op)
      CMD_FILL: paint_box(0, side - 1, 0, side - 1, colour);
      CMD_DRAW: begin
        if (r < k || c < k || r + k >= side || c + k >= side) begin
          res.status = 1'b1;
        end else if (sty == STYLE_OUTLINE) begin
          paint_box(r - k, r - k, c - k, c + k, colour);
          paint_box(r + k, r + k, c - k, c + k, colour);
          paint_box(r - k, r + k, c - k, c - k, colour);
          paint_box(r - k, r + k, c + k, c + k, colour);
        end else if (sty == STYLE_FILLED) begin
          paint_box(r - k, r + k, c - k, c + k, colour);
        end
      end
      CMD_READ: begin
        if (r >= side || c >= side) res.status = 1'b1;
        else res.pixel = frame_model[r*SIDE_MAX + c];
      end
      default: ;
    endcase
  endtask

  // Offers one request, starting at a falling edge; returns at the falling edge after
  // acceptance with in_tvalid still high.
  task automatic send_request(input cmd_t op, input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] rad, input logic [7:0] colour,
                              input style_t sty, input bit typed,
                              input raster_result_t typed_res);
    raster_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, sty, colour, rad, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    raster_apply(op, col, row, rad, colour, sty, predicted);
    // Typed rows carry their own answer; the predictor still tracks the buffer.
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Size write: only once every result is back and the engine has gone idle.
  task automatic program_size(input logic [8:0] v);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    img_size_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n_req, input logic [8:0] size_val,
                              input bit allow_fill, input bit squeeze);
    int side, pick, c, r, k;
    cmd_t op;
    style_t sty;
    program_size(size_val);
    if (squeeze) hold_off_req = 1'b1;
    side = active_side(size_val);
    for (int i = 0; i < n_req; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) op = allow_fill ? CMD_FILL : CMD_DRAW;
      else if (pick < 18) op = CMD_NOP;
      else if (pick < 62) op = CMD_DRAW;
      else op = CMD_READ;
      // Mostly on-image centres and small radii so many squares land in bounds.
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, side - 1);
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, side - 1);
      k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                      : $urandom_range(0, (side < 24) ? side / 2 : 12);
      sty = style_t'($urandom_range(0, 3));
      // Keep big filled squares cheap on the full-size image.
      if (side > 64 && sty == STYLE_FILLED && k > 40) k = k % 41;
      send_request(op, c[7:0], r[7:0], k[7:0], 8'($urandom_range(0, 255)), sty, 1'b0, '0);
    end
  endtask

  function automatic step_row_t mk_chk(input cmd_t c, input int col, input int row,
                                       input int rad, input int colour, input style_t st,
                                       input int px, input int stat);
    step_row_t s;
    s = '0;
    s.cmd        = c;
    s.col        = col[7:0];
    s.row        = row[7:0];
    s.rad        = rad[7:0];
    s.colour     = colour[7:0];
    s.style      = st;
    s.typed      = 1'b1;
    s.exp_pixel  = px[7:0];
    s.exp_status = stat[0];
    return s;
  endfunction

  function automatic step_row_t mk_req(input cmd_t c, input int col, input int row,
                                       input int rad, input int colour, input style_t st);
    step_row_t s;
    s = mk_chk(c, col, row, rad, colour, st, 0, 0);
    s.typed = 1'b0;
    return s;
  endfunction

  function automatic step_row_t mk_cfg(input int size);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.size   = size[8:0];
    return s;
  endfunction

  // Receiver: random backpressure, plus one long hold-off on request from the stimulus.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    raster_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result pixel=%0h status=%0b", out_tdata, out_tuser));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.pixel)
          flag_error($sformatf("pixel_value got %0h want %0h", out_tdata, want.pixel));
        if (out_tuser[0] !== want.status)
          flag_error($sformatf("status got %0b want %0b", out_tuser[0], want.status));
      end
    end
  end

  initial begin : stimulus
    step_row_t steps [$];
    step_row_t s;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    hold_off_req  = 1'b0;
    err_count     = 0;
    send_idle_pct = 28;
    recv_idle_pct = 72;

    // Full-size fill first so every later read hits a written pixel.
    steps.push_back(mk_chk(CMD_FILL, 0, 0, 0, 8'h5A, STYLE_NONE0, 0, 0));
    steps.push_back(mk_chk(CMD_READ, 0, 0, 0, 0, STYLE_NONE0, 8'h5A, 0));
    steps.push_back(mk_chk(CMD_READ, 255, 255, 0, 0, STYLE_NONE0, 8'h5A, 0));
    // nop with every field bit set
    steps.push_back(mk_chk(CMD_NOP, 255, 255, 255, 255, STYLE_NONE3, 0, 0));
    // largest outline that still fits
    steps.push_back(mk_chk(CMD_DRAW, 128, 128, 127, 8'hFF, STYLE_OUTLINE, 0, 0));
    steps.push_back(mk_req(CMD_READ, 1, 200, 0, 0, STYLE_NONE0));
    steps.push_back(mk_chk(CMD_DRAW, 0, 0, 1, 8'h44, STYLE_FILLED, 0, 1));
    // single pixel square in the far corner
    steps.push_back(mk_chk(CMD_DRAW, 255, 255, 0, 8'h00, STYLE_FILLED, 0, 0));
    steps.push_back(mk_req(CMD_READ, 255, 255, 0, 0, STYLE_NONE0));
    // styles with no meaning: in bounds draws nothing, out of bounds still flags
    steps.push_back(mk_chk(CMD_DRAW, 10, 10, 3, 8'h11, STYLE_NONE0, 0, 0));
    steps.push_back(mk_req(CMD_READ, 10, 7, 0, 0, STYLE_NONE0));
    steps.push_back(mk_chk(CMD_DRAW, 2, 100, 3, 8'h22, STYLE_NONE3, 0, 1));
    // edge just one past the image, then the largest radius
    steps.push_back(mk_chk(CMD_DRAW, 128, 128, 128, 8'h66, STYLE_OUTLINE, 0, 1));
    steps.push_back(mk_chk(CMD_DRAW, 255, 255, 255, 8'h99, STYLE_FILLED, 0, 1));
    // smallest image
    steps.push_back(mk_cfg(1));
    steps.push_back(mk_chk(CMD_FILL, 0, 0, 0, 8'h33, STYLE_NONE0, 0, 0));
    steps.push_back(mk_req(CMD_READ, 0, 0, 0, 0, STYLE_NONE0));
    steps.push_back(mk_chk(CMD_READ, 1, 0, 0, 0, STYLE_NONE0, 0, 1));
    steps.push_back(mk_chk(CMD_DRAW, 0, 0, 0, 8'h77, STYLE_OUTLINE, 0, 0));
    // size zero behaves as one
    steps.push_back(mk_cfg(0));
    steps.push_back(mk_chk(CMD_READ, 0, 255, 0, 0, STYLE_NONE0, 0, 1));
    steps.push_back(mk_req(CMD_READ, 0, 0, 0, 0, STYLE_NONE0));
    // oversize clamps to the full side; buffer contents survive the change
    steps.push_back(mk_cfg(511));
    steps.push_back(mk_req(CMD_READ, 255, 255, 0, 0, STYLE_NONE0));
    steps.push_back(mk_cfg(20));
    steps.push_back(mk_chk(CMD_DRAW, 10, 10, 10, 8'hC3, STYLE_FILLED, 0, 1));
    steps.push_back(mk_chk(CMD_DRAW, 9, 9, 9, 8'hC3, STYLE_FILLED, 0, 0));
    steps.push_back(mk_req(CMD_READ, 18, 0, 0, 0, STYLE_NONE0));
    steps.push_back(mk_chk(CMD_READ, 20, 5, 0, 0, STYLE_NONE0, 0, 1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    img_size_model = 9'(SIZE_RESET);
    @(negedge clk);

    foreach (steps[i]) begin
      s = steps[i];
      if (s.is_cfg) program_size(s.size);
      else send_request(s.cmd, s.col, s.row, s.rad, s.colour, s.style, s.typed,
                        {s.exp_pixel, s.exp_status});
    end

    random_phase(25, 9'($urandom_range(2, 31)), 1'b1, 1'b0);
    send_idle_pct = 72;
    recv_idle_pct = 28;
    // long receiver hold-off here so the engine backs up into its input
    random_phase(25, 9'($urandom_range(32, 64)), 1'b1, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(25, 9'($urandom_range(65, 511)), 1'b0, 1'b0);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0) $display("[square_draw_raster_engine] OK");
    else $display("[square_draw_raster_engine] ERROR");
    $finish;
  end

endmodule
